FILE: hdl/max_window_spread_top_defines.svh
// Assertion macros for the max_window_spread block.
// Used by the control module; depends on nothing else.
`ifndef MAX_WINDOW_SPREAD_TOP_DEFINES_SVH
`define MAX_WINDOW_SPREAD_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising edge of clk outside reset.
`define MWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked on the rising edge of clk outside reset.
`define MWS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MWS_ASSERT_IMP(lbl, ante, cons)
`define MWS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/mws_pkg.sv
// Package for the max_window_spread block: widths, defaults, control types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mws_pkg;

  localparam int VAL_W          = 31;
  localparam int LEN_W          = 11;
  localparam int WINDOW_MAX_DEF = 1024;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

  // Sequencer states.
  typedef enum logic [0:0] {
    ST_RUN,
    ST_DRAIN
  } mws_state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic             shift;
    logic             tap_en;
    logic [LEN_W-1:0] win_len;
  } mws_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/max_window_spread_top.sv
// Top level of the max_window_spread block: a chain of window cells and the
// sequencer. Depends on mws_pkg, mws_cell and mws_ctrl.
//
// Usage: values of a sequence enter on the in_ channel, one per transfer, with
// in_is_last marking the final value. While a sequence runs, in_stall stays
// low and a value may enter every cycle. After the last value the block stalls
// the input while the chain drains to a depth of L, where L is the window length
// if the sequence completed at least one window and 0 otherwise: the spread of
// the deepest cell walks down the cell chain one cell a cycle. It then loads the
// best spread into the output register and raises out_valid.
// The result waits in that register while out_stall is high; the next
// sequence may already enter. A further drain cannot finish, and the input
// stays stalled, until the waiting result is taken.
// cfg_window_len is written with cfg_valid (cfg_ready is always high) and
// should only change while the block is idle.
// Reset (rst_n low at a clock edge) sets window_len to 1 and clears the fill
// count, best spread and output valid; the cell values need no reset.
`default_nettype none

module max_window_spread_top
  import mws_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [VAL_W-1:0] in_sample_value,
  input  wire logic             in_is_last,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [VAL_W-1:0] out_best_spread,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_window_len
);

  mws_ctl_t         ctl;
  logic [VAL_W-1:0] hi_w   [WINDOW_MAX+1];
  logic [VAL_W-1:0] lo_w   [WINDOW_MAX+1];
  logic [VAL_W-1:0] best_w [WINDOW_MAX+1];

  // The first cell extends an empty span, so it sees the sample on both sides.
  assign hi_w[0]            = in_sample_value;
  assign lo_w[0]            = in_sample_value;
  assign best_w[WINDOW_MAX] = '0;

  // Row of window cells.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    mws_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .sample   (in_sample_value),
      .hi_in    (hi_w[i]),
      .lo_in    (lo_w[i]),
      .best_in  (best_w[i+1]),
      .hi_out   (hi_w[i+1]),
      .lo_out   (lo_w[i+1]),
      .best_out (best_w[i])
    );
  end

  // Sequencer.
  mws_ctrl #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_best_spread (out_best_spread),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_window_len  (cfg_window_len),
    .chain_best      (best_w[0]),
    .ctl             (ctl)
  );

endmodule

`default_nettype wire

FILE: hdl/mws_cell.sv
// One cell of the window chain: running max and min of the newest IDX+1 values,
// plus one stage of the spread collection chain. Depends on mws_pkg.
`default_nettype none

module mws_cell
  import mws_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mws_ctl_t         ctl,
  input  wire logic [VAL_W-1:0] sample,
  input  wire logic [VAL_W-1:0] hi_in,
  input  wire logic [VAL_W-1:0] lo_in,
  input  wire logic [VAL_W-1:0] best_in,
  output logic      [VAL_W-1:0] hi_out,
  output logic      [VAL_W-1:0] lo_out,
  output logic      [VAL_W-1:0] best_out
);

  logic [VAL_W-1:0] hi_r, hi_nxt;
  logic [VAL_W-1:0] lo_r, lo_nxt;
  logic [VAL_W-1:0] best_r, best_nxt;
  logic             tap_r, tap_nxt;
  logic [VAL_W-1:0] cand;
  logic             hit;

  // This cell holds the window when its span equals the window length.
  assign hit = (32'(ctl.win_len) == 32'(IDX + 1));

  // Extend the neighbour's span by the new sample.
  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (ctl.shift) begin
      hi_nxt = (sample > hi_in) ? sample : hi_in;
      lo_nxt = (sample < lo_in) ? sample : lo_in;
    end
  end

  assign tap_nxt = ctl.shift & ctl.tap_en & hit;

  // Spread of the freshly updated window, merged into the collection chain.
  assign cand     = tap_r ? (hi_r - lo_r) : '0;
  assign best_nxt = (best_in > cand) ? best_in : cand;

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r  <= 1'b0;
      best_r <= '0;
    end else begin
      tap_r  <= tap_nxt;
      best_r <= best_nxt;
    end
  end

  assign hi_out   = hi_r;
  assign lo_out   = lo_r;
  assign best_out = best_r;

endmodule

`default_nettype wire

FILE: hdl/mws_ctrl.sv
// Sequencer of the max_window_spread block: handshakes, fill count, drain,
// result register and the window length register. Depends on mws_pkg.
`default_nettype none
`include "max_window_spread_top_defines.svh"

module mws_ctrl
  import mws_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_is_last,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [VAL_W-1:0] out_best_spread,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_window_len,
  input  wire logic [VAL_W-1:0] chain_best,
  output mws_ctl_t              ctl
);

  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int CNT_W  = LEN_W + 1;

  mws_state_t       state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] maxlen_r, maxlen_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0] best_r, best_nxt;
  logic [VAL_W-1:0] out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             tap_en;
  logic             finish;

  assign accept = in_valid & ~in_stall;

  // Window complete: legal length and enough values of this sequence held.
  assign fill_inc = (fill_r == FILL_W'(WINDOW_MAX)) ? fill_r : fill_r + FILL_W'(1);
  assign tap_en   = (len_r != '0) && (32'(len_r) <= 32'(WINDOW_MAX))
                    && (32'(fill_inc) >= 32'(len_r));

  // Drain is over once every spread has reached the collector.
  assign finish = (state_r == ST_DRAIN) && (cnt_r == '0)
                  && (!out_valid_r || !out_stall);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (accept && in_is_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (finish) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall = 1'b1;
    case (state_r)
      ST_RUN:   in_stall = 1'b0;
      ST_DRAIN: in_stall = 1'b1;
      default:  in_stall = 1'b1;
    endcase
  end

  // Sequence bookkeeping, drain counter and collector.
  always_comb begin
    fill_nxt      = fill_r;
    maxlen_nxt    = maxlen_r;
    cnt_nxt       = cnt_r;
    best_nxt      = (chain_best > best_r) ? chain_best : best_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    len_nxt       = (cfg_valid && cfg_ready) ? cfg_window_len : len_r;
    if (accept) begin
      fill_nxt = fill_inc;
      if (tap_en && (len_r > maxlen_r)) maxlen_nxt = len_r;
      if (in_is_last) cnt_nxt = CNT_W'(maxlen_nxt) + CNT_W'(1);
    end
    if ((state_r == ST_DRAIN) && (cnt_r != '0)) cnt_nxt = cnt_r - CNT_W'(1);
    if (finish) begin
      out_data_nxt  = best_r;
      out_valid_nxt = 1'b1;
      best_nxt      = '0;
      fill_nxt      = '0;
      maxlen_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      fill_r      <= '0;
      len_r       <= LEN_RESET;
      maxlen_r    <= '0;
      cnt_r       <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      maxlen_r    <= maxlen_nxt;
      cnt_r       <= cnt_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_best_spread = out_data_r;

  assign ctl.shift   = accept;
  assign ctl.tap_en  = tap_en;
  assign ctl.win_len = len_r;

  // A last transfer always starts a drain.
  `MWS_ASSERT_NXT(a_last_drains, accept && in_is_last, state_r == ST_DRAIN)
  // The fill count never passes the store depth.
  `MWS_ASSERT_IMP(a_fill_bound, 1'b1, 32'(fill_r) <= 32'(WINDOW_MAX))
  // A finished drain leaves the collector and fill count clear.
  `MWS_ASSERT_NXT(a_finish_clears, finish, (fill_r == '0) && (maxlen_r == '0))
  // A window is never taken with a zero length.
  `MWS_ASSERT_IMP(a_tap_len, tap_en, len_r != '0)

endmodule

`default_nettype wire
